// File: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helper functions of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // field widths of the request and result transfers
    localparam int SIZE_W      = 17;
    localparam int ADDR_W      = 33;
    localparam int CNT_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int MAX_ORD_W   = 4;

    // order arithmetic, wide enough for any region order up to 31
    localparam int ORDER_W     = 5;

    // bitmap rows
    localparam int ROW_W       = 32;
    localparam int ROW_BW      = 5;

    // configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef logic [ORDER_W-1:0]  order_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_BAD_SIZE = 2'd1;
    localparam status_t STATUS_FULL     = 2'd2;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_ORDER = 1'b0;
    localparam logic REG_BASE      = 1'b1;

    localparam logic [MAX_ORD_W-1:0] MAX_ORDER_RESET = 4'd12;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOCATE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_ADDR,
        ST_ANC_RD,
        ST_ANC_WR,
        ST_BUD_RD,
        ST_BUD_CHK,
        ST_PAR_RD,
        ST_PAR_WR,
        ST_SUB_INIT,
        ST_SUB_RD,
        ST_SUB_WR
    } state_t;

    // number of significant bits of v
    function automatic order_t bit_len(input logic [SIZE_W-1:0] v);
        order_t n;
        n = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                n = ORDER_W'(i + 1);
            end
        end
        return n;
    endfunction

    // index of the lowest set bit, zero when none
    function automatic logic [ROW_BW-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [ROW_BW-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = ROW_BW'(i);
            end
        end
        return idx;
    endfunction

    // ones from bit lo_b up to bit hi_b inclusive
    function automatic logic [ROW_W-1:0] span_mask(input logic [ROW_BW-1:0] lo_b,
                                                   input logic [ROW_BW-1:0] hi_b);
        logic [ROW_W-1:0] ones;
        ones = '1;
        return (ones << lo_b) & (ones >> (~hi_b));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bba_if.sv
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [bba_pkg::SIZE_W-1:0]   request_size;
    logic [bba_pkg::ADDR_W-1:0]   block_address;

    modport source (output valid, output operation, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input block_address, output ready);
endinterface

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::STATUS_W-1:0] status;
    logic [bba_pkg::ADDR_W-1:0]   granted_address;
    logic [bba_pkg::SIZE_W-1:0]   granted_size;
    logic [bba_pkg::SIZE_W-1:0]   free_bytes_now;
    logic [bba_pkg::CNT_W-1:0]    alloc_requests_now;
    logic [bba_pkg::CNT_W-1:0]    size_failures_now;
    logic [bba_pkg::CNT_W-1:0]    full_failures_now;

    modport source (output valid, output status, output granted_address,
                    output granted_size, output free_bytes_now,
                    output alloc_requests_now, output size_failures_now,
                    output full_failures_now, input ready);
    modport sink   (input valid, input status, input granted_address,
                    input granted_size, input free_bytes_now,
                    input alloc_requests_now, input size_failures_now,
                    input full_failures_now, output ready);
endinterface

`default_nettype wire

// File: rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^CAP_ORDER byte region, kept as a bitmap tree in a
// row memory and walked by a small sequencer one row per access.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            carries
//  -------   ---   ------------------   -----------------------------------
//  req       in    valid / ready        operation, request_size, block_address
//  rsp       out   valid / ready        status, grant, free bytes, counters
//  apb       in    psel/penable/pready  max_block_order (0x0), base_address (0x4)
//
//  one request in flight; req.ready high only while idle
//  alloc scans the level's rows, marks ancestors, then marks the subtree rows
//  free climbs while the buddy is free, clearing each parent, then clears the subtree rows
//  a refused or full request writes no tree rows
//  after reset a clearing pass writes every bitmap row (16 rows by default)
//  a result waits in its output register; a stalled rsp holds only the next one's end
//
`default_nettype none

module buddy_block_allocator #(
    parameter int CAP_ORDER = 16,
    parameter int MIN_ORDER = 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    bba_req_if.sink                       req,
    bba_rsp_if.source                     rsp,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [bba_pkg::PADDR_W-1:0]   paddr,
    input  wire  [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // tree geometry: node k (heap index plus one) of depth d lies in [2^d, 2^(d+1))
    localparam int TREE_D = CAP_ORDER - MIN_ORDER;
    localparam int KW     = TREE_D + 1;
    localparam int RBW    = bba_pkg::ROW_BW;
    localparam int RW     = bba_pkg::ROW_W;
    localparam int ROW_AW = (KW > RBW) ? KW - RBW : 1;
    localparam int ROWS   = (KW > RBW) ? (1 << (KW - RBW)) : 1;
    localparam int FBW    = CAP_ORDER + 1;
    localparam int OW     = bba_pkg::ORDER_W;
    localparam int AW     = bba_pkg::ADDR_W;
    localparam int SW     = bba_pkg::SIZE_W;
    localparam int CW     = bba_pkg::CNT_W;

    localparam bba_pkg::order_t CAP_ORD  = OW'(CAP_ORDER);
    localparam bba_pkg::order_t MIN_ORD  = OW'(MIN_ORDER);
    localparam bba_pkg::order_t LEAF_LVL = OW'(TREE_D);

    function automatic logic [ROW_AW-1:0] row_of(input logic [KW-1:0] k);
        return ROW_AW'(k >> RBW);
    endfunction

    function automatic logic [RBW-1:0] bit_of(input logic [KW-1:0] k);
        return RBW'(k);
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    bba_pkg::state_t                 state_reg, state_next;

    // configuration
    logic [bba_pkg::MAX_ORD_W-1:0]   max_order_reg;
    logic [CW-1:0]                   base_reg;

    // persistent counters, shown directly on the result channel
    logic [FBW-1:0]                  free_bytes_reg, free_bytes_next;
    logic [CW-1:0]                   alloc_cnt_reg, alloc_cnt_next;
    logic [CW-1:0]                   size_fail_reg, size_fail_next;
    logic [CW-1:0]                   full_fail_reg, full_fail_next;

    // result register
    logic                            out_valid_reg, out_valid_next;
    bba_pkg::status_t                out_status_reg, out_status_next;
    logic [AW-1:0]                   out_addr_reg, out_addr_next;
    logic [SW-1:0]                   out_size_reg, out_size_next;

    // request being worked on
    bba_pkg::op_t                    op_reg, op_next;
    logic [SW-1:0]                   size_reg, size_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    bba_pkg::status_t                status_reg, status_next;
    bba_pkg::order_t                 l_reg, l_next;         // block order
    bba_pkg::order_t                 d_reg, d_next;         // block depth
    bba_pkg::order_t                 top_reg, top_next;     // depth of largest blocks
    logic [AW-1:0]                   off_reg, off_next;     // block offset in region

    // tree walk
    logic [KW-1:0]                   k0_reg, k0_next;       // the block's node
    logic [KW-1:0]                   cur_k_reg, cur_k_next; // node on the upward walk
    bba_pkg::order_t                 walk_lvl_reg, walk_lvl_next;
    bba_pkg::order_t                 sub_lvl_reg, sub_lvl_next;
    logic [KW-1:0]                   lo_reg, lo_next;       // node span of this level
    logic [KW-1:0]                   hi_reg, hi_next;
    logic [ROW_AW-1:0]               row_reg, row_next;     // also the clearing sweep

    // bitmap memory
    logic [RW-1:0]                   map_mem [ROWS];
    logic [RW-1:0]                   mem_rdata_reg;
    logic [ROW_AW-1:0]               mem_addr;
    logic                            mem_we;
    logic [RW-1:0]                   mem_wdata;

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign req.ready              = (state_reg == bba_pkg::ST_IDLE);
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.granted_address    = out_addr_reg;
    assign rsp.granted_size       = out_size_reg;
    assign rsp.free_bytes_now     = SW'(free_bytes_reg);
    assign rsp.alloc_requests_now = alloc_cnt_reg;
    assign rsp.size_failures_now  = size_fail_reg;
    assign rsp.full_failures_now  = full_fail_reg;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            bba_pkg::REG_MAX_ORDER: prdata = bba_pkg::PDATA_W'(max_order_reg);
            bba_pkg::REG_BASE:      prdata = base_reg;
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // bitmap memory: one port, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= map_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        bba_pkg::order_t   m_ord;
        bba_pkg::order_t   sz_len;
        bba_pkg::order_t   alloc_l;
        bba_pkg::order_t   lvl_dn;
        logic [SW-1:0]     size_m1;
        logic [AW-1:0]     off_calc;
        logic              bad;
        logic              pow2;
        logic [KW-1:0]     level_first;
        logic [KW-1:0]     par_k;
        logic [KW-1:0]     bud_k;
        logic [RBW-1:0]    lo_b;
        logic [RBW-1:0]    hi_b;
        logic [RW-1:0]     row_mask;
        logic [RW-1:0]     free_vec;
        logic [FBW-1:0]    gsize_fb;
        logic [FBW:0]      fb_sum;
        logic [FBW:0]      fb_cap;

        // largest grantable order, capped at the region
        m_ord = (OW'(max_order_reg) > CAP_ORD) ? CAP_ORD : OW'(max_order_reg);

        size_m1  = size_reg - SW'(1);
        sz_len   = bba_pkg::bit_len(size_m1);
        alloc_l  = (sz_len < MIN_ORD) ? MIN_ORD : sz_len;
        off_calc = addr_reg - AW'(base_reg);
        pow2     = (size_reg != '0) && ((size_reg & size_m1) == '0);

        level_first = KW'(1) << d_reg;
        par_k       = cur_k_reg >> 1;
        bud_k       = cur_k_reg ^ KW'(1);
        lvl_dn      = walk_lvl_reg - OW'(1);

        // bits of the current row inside the span [lo, hi]
        lo_b     = (row_reg == row_of(lo_reg)) ? bit_of(lo_reg) : '0;
        hi_b     = (row_reg == row_of(hi_reg)) ? bit_of(hi_reg) : '1;
        row_mask = bba_pkg::span_mask(lo_b, hi_b);
        free_vec = ~mem_rdata_reg & row_mask;

        gsize_fb = FBW'(1) << l_reg;
        fb_sum   = (FBW+1)'(free_bytes_reg) + (FBW+1)'(size_reg);
        fb_cap   = (FBW+1)'(1) << CAP_ORDER;

        bad = 1'b0;

        state_next      = state_reg;
        free_bytes_next = free_bytes_reg;
        alloc_cnt_next  = alloc_cnt_reg;
        size_fail_next  = size_fail_reg;
        full_fail_next  = full_fail_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_size_next   = out_size_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        status_next     = status_reg;
        l_next          = l_reg;
        d_next          = d_reg;
        top_next        = top_reg;
        off_next        = off_reg;
        k0_next         = k0_reg;
        cur_k_next      = cur_k_reg;
        walk_lvl_next   = walk_lvl_reg;
        sub_lvl_next    = sub_lvl_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        row_next        = row_reg;

        mem_addr  = row_reg;
        mem_we    = 1'b0;
        mem_wdata = '0;

        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (row_reg == ROW_AW'(ROWS - 1))
                begin
                    row_next   = '0;
                    state_next = bba_pkg::ST_IDLE;
                end
                else
                begin
                    row_next = row_reg + ROW_AW'(1);
                end
            end

            bba_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = bba_pkg::op_t'(req.operation);
                    size_next  = req.request_size;
                    addr_next  = req.block_address;
                    state_next = bba_pkg::ST_DECODE;
                end
            end

            bba_pkg::ST_DECODE:
            begin
                if (op_reg == bba_pkg::OP_ALLOC)
                begin
                    bad    = (m_ord < MIN_ORD) || (size_reg == '0) || (sz_len > m_ord);
                    l_next = alloc_l;
                    d_next = CAP_ORD - alloc_l;
                end
                else
                begin
                    bad = !pow2 || (m_ord < MIN_ORD) || (sz_len < MIN_ORD)
                          || (sz_len > m_ord) || (addr_reg < AW'(base_reg))
                          || ((off_calc >> CAP_ORDER) != '0)
                          || ((off_calc[SW-1:0] & size_m1) != '0);
                    l_next = sz_len;
                    d_next = CAP_ORD - sz_len;
                end
                top_next    = CAP_ORD - m_ord;
                off_next    = off_calc;
                status_next = bad ? bba_pkg::STATUS_BAD_SIZE : bba_pkg::STATUS_OK;
                state_next  = bad ? bba_pkg::ST_ADDR : bba_pkg::ST_LOCATE;
            end

            bba_pkg::ST_LOCATE:
            begin
                if (op_reg == bba_pkg::OP_ALLOC)
                begin
                    // scan the whole level for the lowest free node
                    lo_next    = level_first;
                    hi_next    = (level_first << 1) - KW'(1);
                    row_next   = row_of(level_first);
                    state_next = bba_pkg::ST_SRCH_RD;
                end
                else
                begin
                    k0_next       = level_first + KW'(off_reg >> l_reg);
                    cur_k_next    = level_first + KW'(off_reg >> l_reg);
                    walk_lvl_next = d_reg;
                    state_next    = (d_reg > top_reg) ? bba_pkg::ST_BUD_RD
                                                      : bba_pkg::ST_SUB_INIT;
                end
            end

            bba_pkg::ST_SRCH_RD:
            begin
                state_next = bba_pkg::ST_SRCH_CHK;
            end

            bba_pkg::ST_SRCH_CHK:
            begin
                if (free_vec != '0)
                begin
                    k0_next    = KW'({row_reg, bba_pkg::lowest_set(free_vec)});
                    state_next = bba_pkg::ST_ADDR;
                end
                else if (row_reg == row_of(hi_reg))
                begin
                    status_next = bba_pkg::STATUS_FULL;
                    state_next  = bba_pkg::ST_ADDR;
                end
                else
                begin
                    row_next   = row_reg + ROW_AW'(1);
                    state_next = bba_pkg::ST_SRCH_RD;
                end
            end

            // offset of the found block; failures pass straight to the result
            bba_pkg::ST_ADDR:
            begin
                if (status_reg != bba_pkg::STATUS_OK)
                begin
                    state_next = bba_pkg::ST_SUB_WR;
                    if (!out_valid_reg || rsp.ready)
                    begin
                        state_next = bba_pkg::ST_IDLE;
                        out_valid_next  = 1'b1;
                        out_status_next = status_reg;
                        out_addr_next   = '0;
                        out_size_next   = '0;
                        if (op_reg == bba_pkg::OP_ALLOC)
                        begin
                            alloc_cnt_next = alloc_cnt_reg + CW'(1);
                            if (status_reg == bba_pkg::STATUS_FULL)
                            begin
                                full_fail_next = full_fail_reg + CW'(1);
                            end
                            else
                            begin
                                size_fail_next = size_fail_reg + CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        state_next = bba_pkg::ST_ADDR;
                    end
                end
                else
                begin
                    off_next      = AW'(k0_reg - lo_reg) << l_reg;
                    cur_k_next    = k0_reg;
                    walk_lvl_next = d_reg;
                    state_next    = (d_reg > top_reg) ? bba_pkg::ST_ANC_RD
                                                      : bba_pkg::ST_SUB_INIT;
                end
            end

            // alloc: mark ancestors up to the top level, stop at one already set
            bba_pkg::ST_ANC_RD:
            begin
                mem_addr   = row_of(par_k);
                state_next = bba_pkg::ST_ANC_WR;
            end

            bba_pkg::ST_ANC_WR:
            begin
                mem_addr = row_of(par_k);
                if (mem_rdata_reg[bit_of(par_k)])
                begin
                    state_next = bba_pkg::ST_SUB_INIT;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = mem_rdata_reg | (RW'(1) << bit_of(par_k));
                    cur_k_next    = par_k;
                    walk_lvl_next = lvl_dn;
                    state_next    = (lvl_dn > top_reg) ? bba_pkg::ST_ANC_RD
                                                       : bba_pkg::ST_SUB_INIT;
                end
            end

            // free: clear parents while the buddy is free
            bba_pkg::ST_BUD_RD:
            begin
                mem_addr   = row_of(bud_k);
                state_next = bba_pkg::ST_BUD_CHK;
            end

            bba_pkg::ST_BUD_CHK:
            begin
                state_next = mem_rdata_reg[bit_of(bud_k)] ? bba_pkg::ST_SUB_INIT
                                                          : bba_pkg::ST_PAR_RD;
            end

            bba_pkg::ST_PAR_RD:
            begin
                mem_addr   = row_of(par_k);
                state_next = bba_pkg::ST_PAR_WR;
            end

            bba_pkg::ST_PAR_WR:
            begin
                mem_addr      = row_of(par_k);
                mem_we        = 1'b1;
                mem_wdata     = mem_rdata_reg & ~(RW'(1) << bit_of(par_k));
                cur_k_next    = par_k;
                walk_lvl_next = lvl_dn;
                state_next    = (lvl_dn > top_reg) ? bba_pkg::ST_BUD_RD
                                                   : bba_pkg::ST_SUB_INIT;
            end

            // whole subtree below the block, one row per read/write pair
            bba_pkg::ST_SUB_INIT:
            begin
                lo_next      = k0_reg;
                hi_next      = k0_reg;
                row_next     = row_of(k0_reg);
                sub_lvl_next = d_reg;
                state_next   = bba_pkg::ST_SUB_RD;
            end

            bba_pkg::ST_SUB_RD:
            begin
                state_next = bba_pkg::ST_SUB_WR;
            end

            bba_pkg::ST_SUB_WR:
            begin
                if (status_reg == bba_pkg::STATUS_OK)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (op_reg == bba_pkg::OP_ALLOC) ? (mem_rdata_reg | row_mask)
                                                              : (mem_rdata_reg & ~row_mask);
                end
                if (status_reg != bba_pkg::STATUS_OK || row_reg == row_of(hi_reg))
                begin
                    if (status_reg != bba_pkg::STATUS_OK || sub_lvl_reg == LEAF_LVL)
                    begin
                        // finished: hand over the result once the output is free
                        status_next = bba_pkg::STATUS_OK;
                        state_next  = bba_pkg::ST_SUB_WR;
                        if (!out_valid_reg || rsp.ready)
                        begin
                            state_next      = bba_pkg::ST_IDLE;
                            out_valid_next  = 1'b1;
                            out_status_next = bba_pkg::STATUS_OK;
                            if (op_reg == bba_pkg::OP_ALLOC)
                            begin
                                alloc_cnt_next  = alloc_cnt_reg + CW'(1);
                                out_addr_next   = AW'(base_reg) + off_reg;
                                out_size_next   = SW'(1) << l_reg;
                                free_bytes_next = (free_bytes_reg >= gsize_fb)
                                                  ? (free_bytes_reg - gsize_fb) : '0;
                            end
                            else
                            begin
                                out_addr_next   = '0;
                                out_size_next   = '0;
                                free_bytes_next = (fb_sum > fb_cap) ? FBW'(fb_cap)
                                                                    : FBW'(fb_sum);
                            end
                        end
                        // last row is written now, the waiting cycles skip the write
                        if (state_next == bba_pkg::ST_SUB_WR)
                        begin
                            status_next = bba_pkg::STATUS_BAD_SIZE;
                        end
                    end
                    else
                    begin
                        lo_next      = lo_reg << 1;
                        hi_next      = (hi_reg << 1) | KW'(1);
                        row_next     = row_of(lo_reg << 1);
                        sub_lvl_next = sub_lvl_reg + OW'(1);
                        state_next   = bba_pkg::ST_SUB_RD;
                    end
                end
                else
                begin
                    row_next   = row_reg + ROW_AW'(1);
                    state_next = bba_pkg::ST_SUB_RD;
                end
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bba_pkg::ST_CLEAR;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            free_bytes_reg <= FBW'(1) << CAP_ORDER;
            alloc_cnt_reg  <= '0;
            size_fail_reg  <= '0;
            full_fail_reg  <= '0;
            max_order_reg  <= bba_pkg::MAX_ORDER_RESET;
            base_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            out_valid_reg  <= out_valid_next;
            free_bytes_reg <= free_bytes_next;
            alloc_cnt_reg  <= alloc_cnt_next;
            size_fail_reg  <= size_fail_next;
            full_fail_reg  <= full_fail_next;
            // configuration transfer on the access phase
            if (psel && penable && pwrite)
            begin
                case (paddr[2])
                    bba_pkg::REG_MAX_ORDER: max_order_reg <= pwdata[bba_pkg::MAX_ORD_W-1:0];
                    bba_pkg::REG_BASE:      base_reg      <= pwdata;
                    default:                base_reg      <= base_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_size_reg   <= out_size_next;
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        status_reg     <= status_next;
        l_reg          <= l_next;
        d_reg          <= d_next;
        top_reg        <= top_next;
        off_reg        <= off_next;
        k0_reg         <= k0_next;
        cur_k_reg      <= cur_k_next;
        walk_lvl_reg   <= walk_lvl_next;
        sub_lvl_reg    <= sub_lvl_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level assertions for the buddy block allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           req_valid,
    input wire                           req_ready,
    input wire                           rsp_valid,
    input wire                           rsp_ready,
    input wire [bba_pkg::STATUS_W-1:0]   status,
    input wire [bba_pkg::ADDR_W-1:0]     granted_address,
    input wire [bba_pkg::SIZE_W-1:0]     granted_size
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(granted_address) && $stable(granted_size))
        else $error("result changed while stalled");

    // one request in flight: busy right after a transfer in
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // failed results carry no grant
    a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != bba_pkg::STATUS_OK |->
            granted_size == '0 && granted_address == '0)
        else $error("grant on a failed request");

    // a grant is a power of two
    a_pow2_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted_size != '0 |-> $onehot(granted_size))
        else $error("granted size not a power of two");

    // a new result follows a busy cycle
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result without work");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .granted_address (rsp.granted_address),
    .granted_size    (rsp.granted_size)
);

`default_nettype wire
